### rtl/tkgs_pkg.sv
package tkgs_pkg;

    localparam int MAX_SIDE = 64;
    localparam int IW       = $clog2(MAX_SIDE);
    localparam int AW       = 2 * IW;
    localparam int CELLS    = MAX_SIDE * MAX_SIDE;
    localparam int NUM_W    = 44;
    localparam int DEN_W    = 19;
    localparam int QUO_W    = 25;
    localparam int DCNT_W   = $clog2(NUM_W);

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_SPLAT = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] CFG_SIDE   = 2'd0;
    localparam logic [1:0] CFG_RADIUS = 2'd1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLEAR = 9'b000000010,
        S_SETUP = 9'b000000100,
        S_BOUND = 9'b000001000,
        S_RD    = 9'b000010000,
        S_MUL   = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_WR    = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    typedef struct packed {
        logic clr_init;
        logic clr_step;
        logic load;
        logic setup;
        logic bound;
        logic rd;
        logic mul;
        logic div_step;
        logic wr;
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic       empty;
        logic       div_last;
        logic       cell_last;
        logic [1:0] op;
    } t_stat;

endpackage

### rtl/tent_kernel_grid_splat_unit.sv
// Read: setup, bound, memory read, then the o_done strobe. Clear: one cell per cycle; a
// grid_side write restarts it. Splat: setup, bound, then per covered cell a read,
// multiply, serial divide and write; default radius 3. One item at a time, o_busy high
// throughout. Reset clears all 4096 cells, o_busy high, as does a grid_side write while
// idle or clearing. Results appear for one cycle on o_done; the receiver cannot stall.
module tent_kernel_grid_splat_unit import tkgs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_operation,
    input  logic signed [15:0] i_source_value,
    input  logic signed [15:0] i_link_weight,
    input  logic [16:0]        i_coord_x,
    input  logic [16:0]        i_coord_y,
    output logic               o_done,
    output logic signed [31:0] o_cell_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [6:0]         i_cfg_data
);

    logic [6:0] r_grid_side;
    logic [5:0] r_spread_radius;
    logic [6:0] side_eff;
    logic       cfg_we, cfg_clear;
    t_cmd       cmd;
    t_stat      stat;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;
    assign cfg_clear   = cfg_we && (i_cfg_index == CFG_SIDE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_side     <= 7'd32;
            r_spread_radius <= 6'd3;
        end else if (cfg_we) begin
            if (i_cfg_index == CFG_SIDE) begin
                r_grid_side <= i_cfg_data;
            end else if (i_cfg_index == CFG_RADIUS) begin
                r_spread_radius <= i_cfg_data[5:0];
            end
        end
    end

    assign side_eff = (r_grid_side == 7'd0) ? 7'd1 :
                      (r_grid_side > 7'(MAX_SIDE)) ? 7'(MAX_SIDE) : r_grid_side;

    tkgs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_cfg_clear (cfg_clear),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (o_busy),
        .o_done      (o_done)
    );

    tkgs_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_side         (side_eff),
        .i_radius       (r_spread_radius),
        .i_operation    (i_operation),
        .i_source_value (i_source_value),
        .i_link_weight  (i_link_weight),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .o_stat         (stat),
        .o_cell_value   (o_cell_value)
    );

endmodule

### rtl/tkgs_ctrl.sv
module tkgs_ctrl import tkgs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_cfg_clear,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_done
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_cfg_clear) begin
                    o_cmd.clr_init = 1'b1;
                    n_state        = S_CLEAR;
                end else if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_CLEAR: begin
                if (i_cfg_clear) begin
                    o_cmd.clr_init = 1'b1;
                end else begin
                    o_cmd.clr_step = 1'b1;
                    if (i_stat.clr_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                if (i_stat.op == OP_CLEAR) begin
                    o_cmd.clr_init = 1'b1;
                    n_state        = S_CLEAR;
                end else if (i_stat.op == OP_SPLAT || i_stat.op == OP_READ) begin
                    n_state = S_BOUND;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BOUND: begin
                o_cmd.bound = 1'b1;
                n_state     = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                if (i_stat.op == OP_READ) begin
                    n_state = S_OUT;
                end else if (i_stat.empty) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                n_state  = i_stat.cell_last ? S_IDLE : S_RD;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_OUT);

endmodule

### rtl/tkgs_dpath.sv
module tkgs_dpath import tkgs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [6:0]         i_side,
    input  logic [5:0]         i_radius,
    input  logic [1:0]         i_operation,
    input  logic signed [15:0] i_source_value,
    input  logic signed [15:0] i_link_weight,
    input  logic [16:0]        i_coord_x,
    input  logic [16:0]        i_coord_y,
    output t_stat              o_stat,
    output logic signed [31:0] o_cell_value
);

    logic [31:0] mem [0:CELLS-1];

    logic [1:0]         r_op;
    logic signed [15:0] r_val, r_wgt;
    logic [16:0]        r_cx, r_cy;
    logic signed [31:0] r_prod;
    logic [7:0]         r_px, r_py;
    logic [6:0]         r_xlo, r_xhi, r_yhi;
    logic               r_empty;
    logic [30:0]        r_mag;
    logic               r_neg;
    logic [DEN_W-1:0]   r_den;
    logic [IW-1:0]      r_i, r_j;
    logic [37:0]        r_m1;
    logic [NUM_W-1:0]   r_quo;
    logic [DEN_W-1:0]   r_rem;
    logic [DCNT_W-1:0]  r_dcnt;
    logic [AW-1:0]      r_clr;
    logic [31:0]        r_rdata;

    logic [6:0]  m_sel, side_m1;
    logic [24:0] sx_full, sy_full;
    logic signed [8:0] s_px, s_py, s_r, s_hi;
    logic signed [8:0] xlo_s, xhi_s, ylo_s, yhi_s;
    logic [7:0]  dxw, dyw;
    logic [6:0]  adx, ady, tx, ty, r1;
    logic [12:0] r1sq;
    logic [44:0] num_full;
    logic [DEN_W:0] dtrial;
    logic [DEN_W:0] dden;
    logic signed [32:0] add_v, sum_v;
    logic [31:0] sat_v;
    logic [7:0]  ix_c, iy_c;
    logic        we;
    logic [AW-1:0] waddr;
    logic [31:0] wdata;

    assign side_m1  = i_side - 7'd1;
    assign m_sel    = (r_op == OP_READ) ? side_m1 : i_side;
    assign sx_full  = r_cx * m_sel + 25'd32768;
    assign sy_full  = r_cy * m_sel + 25'd32768;

    assign s_px  = {1'b0, r_px};
    assign s_py  = {1'b0, r_py};
    assign s_r   = {3'b000, i_radius};
    assign s_hi  = {2'b00, side_m1};
    assign xlo_s = (s_px - s_r < 0) ? 9'sd0 : s_px - s_r;
    assign ylo_s = (s_py - s_r < 0) ? 9'sd0 : s_py - s_r;
    assign xhi_s = (s_px + s_r > s_hi) ? s_hi : s_px + s_r;
    assign yhi_s = (s_py + s_r > s_hi) ? s_hi : s_py + s_r;
    assign ix_c  = (r_px > {1'b0, side_m1}) ? {1'b0, side_m1} : r_px;
    assign iy_c  = (r_py > {1'b0, side_m1}) ? {1'b0, side_m1} : r_py;

    assign r1   = {1'b0, i_radius} + 7'd1;
    assign r1sq = r1 * r1;
    assign dxw  = ({2'b00, r_i} >= r_px) ? {2'b00, r_i} - r_px : r_px - {2'b00, r_i};
    assign dyw  = ({2'b00, r_j} >= r_py) ? {2'b00, r_j} - r_py : r_py - {2'b00, r_j};
    assign adx  = dxw[6:0];
    assign ady  = dyw[6:0];
    assign tx   = r1 - adx;
    assign ty   = r1 - ady;
    assign num_full = r_m1 * ty + {20'd0, r1sq, 12'd0} / 45'd128;

    assign dtrial = {r_rem, r_quo[NUM_W-1]};
    assign dden   = {1'b0, r_den};

    assign add_v = r_neg ? -$signed({8'd0, r_quo[QUO_W-1:0]})
                         : $signed({8'd0, r_quo[QUO_W-1:0]});
    assign sum_v = $signed({r_rdata[31], r_rdata}) + add_v;
    assign sat_v = (sum_v[32] != sum_v[31]) ? (sum_v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                            : sum_v[31:0];

    assign we    = i_cmd.clr_step | i_cmd.wr;
    assign waddr = i_cmd.clr_step ? r_clr : {r_j, r_i};
    assign wdata = i_cmd.clr_step ? 32'd0 : sat_v;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[{r_j, r_i}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_init) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_val <= i_source_value;
            r_wgt <= i_link_weight;
            r_cx  <= i_coord_x;
            r_cy  <= i_coord_y;
        end
        if (i_cmd.setup) begin
            r_prod <= r_val * r_wgt;
            r_px   <= sx_full[23:16];
            r_py   <= sy_full[23:16];
        end
        if (i_cmd.bound) begin
            r_mag <= r_prod[31] ? 31'(-{r_prod[31], r_prod}) : r_prod[30:0];
            r_neg <= r_prod[31];
            r_den <= {r1sq, 6'd0};
            if (r_op == OP_READ) begin
                r_i <= ix_c[IW-1:0];
                r_j <= iy_c[IW-1:0];
            end else begin
                r_xlo   <= xlo_s[6:0];
                r_xhi   <= xhi_s[6:0];
                r_yhi   <= yhi_s[6:0];
                r_empty <= (xlo_s > xhi_s) || (ylo_s > yhi_s);
                r_i     <= xlo_s[IW-1:0];
                r_j     <= ylo_s[IW-1:0];
            end
        end
        if (i_cmd.rd) begin
            r_m1 <= r_mag * tx;
        end
        if (i_cmd.mul) begin
            r_quo  <= num_full[NUM_W-1:0];
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 1'b1;
            if (dtrial >= dden) begin
                r_rem <= DEN_W'(dtrial - dden);
                r_quo <= {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= dtrial[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], 1'b0};
            end
        end
        if (i_cmd.wr) begin
            if ({1'b0, r_i} == r_xhi) begin
                r_i <= r_xlo[IW-1:0];
                r_j <= r_j + 1'b1;
            end else begin
                r_i <= r_i + 1'b1;
            end
        end
    end

    assign o_stat.clr_last  = (r_clr == AW'(CELLS - 1));
    assign o_stat.empty     = r_empty;
    assign o_stat.div_last  = (r_dcnt == DCNT_W'(NUM_W - 1));
    assign o_stat.cell_last = ({1'b0, r_i} == r_xhi) && ({1'b0, r_j} == r_yhi);
    assign o_stat.op        = r_op;
    assign o_cell_value     = r_rdata;

endmodule
